/* rtl/ksa_pkg.sv */
`default_nettype none

package ksa_pkg;

   // Pool geometry.
   localparam int OWNER_COUNT     = 65536;
   localparam int SLOTS_PER_SHEET = 256;
   localparam int SHEET_COUNT     = 4;
   localparam int SHEET_WIDTH     = 192;
   localparam int TILE_WIDTH      = 12;
   localparam int TILE_HEIGHT     = 8;

   localparam int POOL_SLOTS    = SLOTS_PER_SHEET * SHEET_COUNT;
   localparam int TILES_PER_ROW = SHEET_WIDTH / TILE_WIDTH;

   // Field widths of the request and response words.
   localparam int REQ_W    = 2;
   localparam int OWNER_W  = 16;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 10;
   localparam int SHEET_W  = 2;
   localparam int POS_W    = 8;
   localparam int PX_W     = 8;
   localparam int PY_W     = 7;

   // Storage widths.
   localparam int MAP_AW   = $clog2(OWNER_COUNT);
   localparam int MAP_W    = SLOT_W + 1;
   localparam int STACK_AW = $clog2(POOL_SLOTS);
   localparam int DEPTH_W  = STACK_AW + 1;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_EXISTING   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REUSED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEW        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic lookup;
      logic commit;
      logic sweep_start;
      logic sweep_step;
   } ksa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic sweep_last;
   } ksa_stat_type;

endpackage

`default_nettype wire

/* rtl/ksa_channels.sv */
`default_nettype none

interface ksa_req_if;
   import ksa_pkg::*;

   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [OWNER_W-1:0] owner_id;

   modport source (output valid, output req_type, output owner_id, input ready);
   modport sink   (input valid, input req_type, input owner_id, output ready);
endinterface

interface ksa_rsp_if;
   import ksa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [SHEET_W-1:0]  sheet;
   logic [POS_W-1:0]    slot_in_sheet;
   logic [PX_W-1:0]     pixel_x;
   logic [PY_W-1:0]     pixel_y;
   logic                first_in_sheet;

   modport source (output valid, output status, output slot, output sheet,
                   output slot_in_sheet, output pixel_x, output pixel_y,
                   output first_in_sheet, input ready);
   modport sink   (input valid, input status, input slot, input sheet,
                   input slot_in_sheet, input pixel_x, input pixel_y,
                   input first_in_sheet, output ready);
endinterface

`default_nettype wire

/* rtl/keyed_slot_allocator.sv */
`default_nettype none

// Keyed slot allocator. Each request word names an owner id and asks to
// assign it a tile slot, to free its slot, or to clear every mapping. An
// assign returns the owner's current slot if it has one, else the most
// recently freed slot, else the next never-used slot, else reports the pool
// as full. Every request except the unused type code returns exactly one
// response word carrying the status, the slot, its sheet, its position in
// the sheet, the pixel origin of the tile and a flag when a new slot opens a
// sheet. Assign and free run as a lookup step, which reads the owner map and
// the top of the free stack, and a decide step, which decides, writes back
// and loads the response register. The response register lets the next
// request start its map read while the previous word still waits; the
// decide step waits until that register is free. A clear sweeps the whole
// owner map, one entry per cycle, and its word is then loaded by the decide
// step. After reset the same sweep runs and no request is accepted until it
// finishes; no word is produced by it.
module keyed_slot_allocator (
   input  wire logic clock,
   input  wire logic reset,
   ksa_req_if.sink   req_chan,
   ksa_rsp_if.source rsp_chan
);
   import ksa_pkg::*;

   ksa_cmd_type  cmd;
   ksa_stat_type stat;
   logic         req_ready;

   assign req_chan.ready = req_ready;

   // The controller sequences lookup, commit and the clearing sweep.
   ksa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the owner map, the free stack, the counters and the
   // response register.
   ksa_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_type (req_chan.req_type),
      .owner_id (req_chan.owner_id),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/ksa_datapath.sv */
`default_nettype none

module ksa_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ksa_pkg::ksa_cmd_type        cmd,
   output ksa_pkg::ksa_stat_type            stat,
   input  wire logic [ksa_pkg::REQ_W-1:0]   req_type,
   input  wire logic [ksa_pkg::OWNER_W-1:0] owner_id,
   ksa_rsp_if.source                        rsp
);
   import ksa_pkg::*;

   logic [MAP_W-1:0]  map_mem   [OWNER_COUNT];
   logic [SLOT_W-1:0] stack_mem [POOL_SLOTS];

   logic [REQ_W-1:0]   op_ff;
   logic [MAP_AW-1:0]  owner_ff;
   logic [MAP_W-1:0]   map_q_ff;
   logic [SLOT_W-1:0]  stack_q_ff;
   logic [DEPTH_W-1:0] free_depth_ff, free_depth_in;
   logic [DEPTH_W-1:0] next_fresh_ff, next_fresh_in;
   logic [MAP_AW-1:0]  sweep_cnt_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SHEET_W-1:0]  sheet_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [PX_W-1:0]     px_ff;
   logic [PY_W-1:0]     py_ff;
   logic                first_ff;

   logic               hit;
   logic [SLOT_W-1:0]  hit_slot;
   logic               have_free, have_fresh, can_push;
   logic [DEPTH_W-1:0] pop_idx;

   logic [STATUS_W-1:0] status_c;
   logic [SLOT_W-1:0]   slot_c;
   logic                fields_c;
   logic                first_c;
   logic                map_we_c;
   logic [MAP_W-1:0]    map_wdata_c;
   logic                pop_c, push_c, fresh_c;
   logic [POS_W-1:0]    pos_c;
   logic [POS_W-1:0]    col_c, row_c;

   assign hit        = map_q_ff[SLOT_W];
   assign hit_slot   = map_q_ff[SLOT_W-1:0];
   assign have_free  = (free_depth_ff != '0);
   assign have_fresh = (next_fresh_ff < DEPTH_W'(POOL_SLOTS));
   assign can_push   = (free_depth_ff < DEPTH_W'(POOL_SLOTS));
   assign pop_idx    = free_depth_ff - DEPTH_W'(1);

   // Lookup: the map entry and the top of the stack are read together.
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         op_ff      <= req_type;
         owner_ff   <= MAP_AW'(owner_id);
         map_q_ff   <= map_mem[MAP_AW'(owner_id)];
         stack_q_ff <= stack_mem[pop_idx[STACK_AW-1:0]];
      end
   end

   always_comb begin
      status_c    = ST_CLEARED;
      slot_c      = '0;
      fields_c    = 1'b0;
      first_c     = 1'b0;
      map_we_c    = 1'b0;
      map_wdata_c = '0;
      pop_c       = 1'b0;
      push_c      = 1'b0;
      fresh_c     = 1'b0;
      case (op_ff)
         REQ_ASSIGN: begin
            if (hit) begin
               status_c = ST_EXISTING;
               slot_c   = hit_slot;
               fields_c = 1'b1;
            end else if (have_free) begin
               status_c    = ST_REUSED;
               slot_c      = stack_q_ff;
               fields_c    = 1'b1;
               map_we_c    = 1'b1;
               map_wdata_c = {1'b1, stack_q_ff};
               pop_c       = 1'b1;
            end else if (have_fresh) begin
               status_c    = ST_NEW;
               slot_c      = SLOT_W'(next_fresh_ff);
               fields_c    = 1'b1;
               map_we_c    = 1'b1;
               map_wdata_c = {1'b1, SLOT_W'(next_fresh_ff)};
               fresh_c     = 1'b1;
            end else begin
               status_c = ST_FULL;
            end
         end
         REQ_FREE: begin
            if (hit) begin
               status_c = ST_FREED;
               slot_c   = hit_slot;
               fields_c = 1'b1;
               map_we_c = 1'b1;
               push_c   = can_push;
            end else begin
               status_c = ST_NOT_MAPPED;
            end
         end
         REQ_CLEAR: status_c = ST_CLEARED;
         default:   status_c = ST_CLEARED;
      endcase

      pos_c = POS_W'(slot_c % SLOTS_PER_SHEET);
      col_c = POS_W'(pos_c % TILES_PER_ROW);
      row_c = POS_W'(pos_c / TILES_PER_ROW);
      if (status_c == ST_NEW) begin
         first_c = (pos_c == '0);
      end
   end

   // Single write port, shared by the clearing sweep and the commit.
   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         map_mem[sweep_cnt_ff] <= '0;
      end else if (cmd.commit && map_we_c) begin
         map_mem[owner_ff] <= map_wdata_c;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && push_c) begin
         stack_mem[free_depth_ff[STACK_AW-1:0]] <= hit_slot;
      end
   end

   always_comb begin
      free_depth_in = free_depth_ff;
      next_fresh_in = next_fresh_ff;
      if (cmd.sweep_start) begin
         free_depth_in = '0;
         next_fresh_in = '0;
      end else if (cmd.commit) begin
         if (pop_c) begin
            free_depth_in = free_depth_ff - DEPTH_W'(1);
         end else if (push_c) begin
            free_depth_in = free_depth_ff + DEPTH_W'(1);
         end
         if (fresh_c) begin
            next_fresh_in = next_fresh_ff + DEPTH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_depth_ff <= '0;
         next_fresh_ff <= '0;
         sweep_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_depth_ff <= free_depth_in;
         next_fresh_ff <= next_fresh_in;
         if (cmd.sweep_start) begin
            sweep_cnt_ff <= '0;
         end else if (cmd.sweep_step) begin
            sweep_cnt_ff <= sweep_cnt_ff + MAP_AW'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_c;
         first_ff  <= first_c;
         if (fields_c) begin
            slot_ff  <= slot_c;
            sheet_ff <= SHEET_W'(slot_c / SLOTS_PER_SHEET);
            pos_ff   <= pos_c;
            px_ff    <= PX_W'(col_c * TILE_WIDTH);
            py_ff    <= PY_W'(row_c * TILE_HEIGHT);
         end else begin
            slot_ff  <= '0;
            sheet_ff <= '0;
            pos_ff   <= '0;
            px_ff    <= '0;
            py_ff    <= '0;
         end
      end
   end

   assign stat.out_free   = !rsp_valid_ff || rsp.ready;
   assign stat.sweep_last = (sweep_cnt_ff == MAP_AW'(OWNER_COUNT - 1));

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.slot           = slot_ff;
   assign rsp.sheet          = sheet_ff;
   assign rsp.slot_in_sheet  = pos_ff;
   assign rsp.pixel_x        = px_ff;
   assign rsp.pixel_y        = py_ff;
   assign rsp.first_in_sheet = first_ff;

endmodule

`default_nettype wire

/* rtl/ksa_ctrl.sv */
`default_nettype none

module ksa_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [ksa_pkg::REQ_W-1:0] req_type,
   output logic                           req_ready,
   input  wire ksa_pkg::ksa_stat_type     stat,
   output ksa_pkg::ksa_cmd_type           cmd
);
   import ksa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECIDE = 3'b010,
      S_SWEEP  = 3'b100
   } ksa_state_type;

   ksa_state_type state_ff, state_in;
   logic          clear_rsp_ff, clear_rsp_in;

   always_comb begin
      state_in     = state_ff;
      clear_rsp_in = clear_rsp_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.lookup = 1'b1;
               case (req_type)
                  REQ_ASSIGN, REQ_FREE: state_in = S_DECIDE;
                  REQ_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     clear_rsp_in    = 1'b1;
                     state_in        = S_SWEEP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = clear_rsp_ff ? S_DECIDE : S_IDLE;
            end
         end
         S_DECIDE: begin
            if (stat.out_free) begin
               cmd.commit   = 1'b1;
               clear_rsp_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Reset starts the map sweep, which emits no word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         clear_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_rsp_ff <= clear_rsp_in;
      end
   end

endmodule

`default_nettype wire
